// ===== sv/jqsjn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jqsjn_pkg: shared types and codes of the job queue
// Job entry layout, action, status, order mode and register index codes.
// ----------------------------------------------------------------------------
package jqsjn_pkg;

   // Actions carried by a request item
   localparam logic [2:0] ActAdd    = 3'd0;
   localparam logic [2:0] ActFinish = 3'd1;
   localparam logic [2:0] ActPeek   = 3'd2;
   localparam logic [2:0] ActQuery  = 3'd3;
   localparam logic [2:0] ActRemove = 3'd4;

   // Result status codes
   localparam logic [1:0] StOk       = 2'd0;
   localparam logic [1:0] StFull     = 2'd1;
   localparam logic [1:0] StEmpty    = 2'd2;
   localparam logic [1:0] StNotFound = 2'd3;

   // Service order modes (code 3 acts as priority order)
   localparam logic [1:0] ModePrio = 2'd0;
   localparam logic [1:0] ModeFifo = 2'd1;
   localparam logic [1:0] ModeSjn  = 2'd2;
   localparam logic [1:0] ModeAlt  = 2'd3;

   // Register indexes of the control port
   localparam logic CsrOrderMode  = 1'b0;
   localparam logic CsrSecPerPage = 1'b1;

   localparam logic [7:0]  SecPerPageReset = 8'd5;
   localparam logic [31:0] WaitMax         = 32'hFFFF_FFFF;

   // One stored job
   typedef struct packed {
      logic [7:0]  src;
      logic [7:0]  prio;
      logic [15:0] pages;
      logic [15:0] ident;
   } job_type;

endpackage

// ===== sv/job_queue_priority_fifo_sjn_top.sv =====
`timescale 1ns / 1ps
// A shortest-job query makes a second pass over the slots to sum pages.
// One item at a time; the single slot memory port pair walks one slot per cycle.
// Reset (synchronous, active high) empties the queue, zeroes the id counter,
// sets priority order and 5 seconds per page; slot contents are not cleared.
// ----------------------------------------------------------------------------
// job_queue_priority_fifo_sjn_top: job queue with selectable service order
// Sorted queue in a slot memory, walked by a small sequencer for each action.
// ----------------------------------------------------------------------------
module job_queue_priority_fifo_sjn_top #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[2:0], page_count[18:3], priority_level[26:19], source_id[34:27],
   // target_job[50:35], zero fill
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], job_ident[17:2], job_pages[33:18], job_priority[41:34],
   // job_source[49:42], wait_seconds[81:50], zero fill
   output logic [87:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import jqsjn_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = 16 + CW;
   localparam int PW = SW + 8;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FSCAN = 3'd1;
   localparam logic [2:0] S_SHUP  = 3'd2;
   localparam logic [2:0] S_PUT   = 3'd3;
   localparam logic [2:0] S_SHDN  = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;
   localparam logic [2:0] S_MUL   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // Control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [15:0]   nid_ff, nid_in;
   logic [1:0]    order_mode_ff;
   logic [7:0]    spp_ff;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Item and working registers
   logic [2:0]    act_ff, act_in;
   logic [15:0]   pages_ff, pages_in;
   logic [7:0]    prio_ff, prio_in;
   logic [7:0]    src_ff, src_in;
   logic [15:0]   target_ff, target_in;
   logic [CW-1:0] ix_ff, ix_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [AW-1:0] pix_ff, pix_in;
   logic          shup_prio_ff, shup_prio_in;
   job_type       ent_ff, ent_in;
   logic [1:0]    status_ff, status_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [87:0]   rsp_data_ff, rsp_data_in;

   // Slot memory access
   logic          slot_we;
   logic [AW-1:0] slot_waddr;
   job_type       slot_wdata;
   logic [AW-1:0] slot_raddr;
   job_type       slot_rdata;

   logic          req_fire;
   logic          issue;
   logic          exhaust;
   logic          match;
   logic [1:0]    cur_mode;
   logic [31:0]   wait_sat;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign cur_mode   = (order_mode_ff == ModeAlt) ? ModePrio : order_mode_ff;
   assign wait_sat   = (64'(prod_ff) > 64'(WaitMax)) ? WaitMax : 32'(prod_ff);

   jqsjn_slot_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_slots (
      .clock      (clock),
      .wr_en      (slot_we),
      .wr_addr    (slot_waddr),
      .wr_data    (slot_wdata),
      .rd_addr    (slot_raddr),
      .rd_data_ff (slot_rdata)
   );

   // Pick the slot to read this cycle; forward walks go up, shifts up go down
   always_comb begin
      issue      = 1'b0;
      slot_raddr = AW'(ix_ff);
      case (state_ff)
         S_FSCAN, S_SUM, S_SHDN: begin
            issue = (ix_ff < occ_ff);
         end
         S_SHUP: begin
            issue      = (ix_ff > lo_ff);
            slot_raddr = AW'(ix_ff - CW'(1));
         end
         default: begin
            issue = 1'b0;
         end
      endcase
      exhaust = !issue && !pend_ff;
   end

   // Match rule of the forward walk
   always_comb begin
      case (act_ff)
         ActAdd:              match = (slot_rdata.pages >= pages_ff);
         ActFinish, ActPeek:  match = 1'b1;
         ActQuery, ActRemove: match = (slot_rdata.ident == target_ff);
         default:             match = 1'b0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      nid_in       = nid_ff;
      act_in       = act_ff;
      pages_in     = pages_ff;
      prio_in      = prio_ff;
      src_in       = src_ff;
      target_in    = target_ff;
      lo_in        = lo_ff;
      pos_in       = pos_ff;
      shup_prio_in = shup_prio_ff;
      ent_in       = ent_ff;
      status_in    = status_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      slot_we      = 1'b0;
      slot_waddr   = pix_ff;
      slot_wdata   = slot_rdata;
      pend_in      = issue;
      pix_in       = slot_raddr;
      ix_in        = ix_ff;

      // Advance the walk pointer when a read goes out
      if (issue) begin
         ix_in = (state_ff == S_SHUP) ? ix_ff - CW'(1) : ix_ff + CW'(1);
      end

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_tdata[2:0];
               pages_in  = req_tdata[18:3];
               prio_in   = req_tdata[26:19];
               src_in    = req_tdata[34:27];
               target_in = req_tdata[50:35];
               status_in = StOk;
               ent_in    = '0;
               sum_in    = '0;
               ix_in     = '0;
               case (req_tdata[2:0])
                  ActAdd: begin
                     if (occ_ff == CW'(DEPTH)) begin
                        status_in = StFull;
                        state_in  = S_DONE;
                     end else begin
                        ent_in = '{src: req_tdata[34:27], prio: req_tdata[26:19],
                                   pages: req_tdata[18:3], ident: nid_ff};
                        nid_in = nid_ff + 16'd1;
                        pos_in = occ_ff;
                        case (cur_mode)
                           ModeSjn: begin
                              state_in = S_FSCAN;
                           end
                           ModeFifo: begin
                              state_in     = S_SHUP;
                              ix_in        = occ_ff;
                              lo_in        = occ_ff;
                              shup_prio_in = 1'b0;
                           end
                           default: begin
                              state_in     = S_SHUP;
                              ix_in        = occ_ff;
                              lo_in        = '0;
                              shup_prio_in = 1'b1;
                           end
                        endcase
                     end
                  end
                  ActFinish, ActPeek: begin
                     if (occ_ff == '0) begin
                        status_in = StEmpty;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_FSCAN;
                     end
                  end
                  ActQuery, ActRemove: begin
                     state_in = S_FSCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // Walk forward to the first matching slot, summing pages on the way
         S_FSCAN: begin
            if (pend_ff) begin
               sum_in = sum_ff + SW'(slot_rdata.pages);
            end
            if (pend_ff && match) begin
               pend_in = 1'b0;
               pos_in  = CW'(pix_ff);
               if (act_ff != ActAdd) begin
                  ent_in = slot_rdata;
               end
               case (act_ff)
                  ActAdd: begin
                     state_in     = S_SHUP;
                     ix_in        = occ_ff;
                     lo_in        = CW'(pix_ff);
                     shup_prio_in = 1'b0;
                  end
                  ActFinish, ActRemove: begin
                     state_in = S_SHDN;
                     ix_in    = CW'(pix_ff) + CW'(1);
                  end
                  ActQuery: begin
                     if (cur_mode == ModeSjn) begin
                        state_in = S_SUM;
                        ix_in    = '0;
                        sum_in   = '0;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end else if (exhaust) begin
               if (act_ff == ActAdd) begin
                  state_in = S_PUT;
                  pos_in   = occ_ff;
               end else begin
                  status_in = StNotFound;
                  state_in  = S_DONE;
               end
            end
         end

         // Move slots up by one from the rear until the insert point
         S_SHUP: begin
            if (pend_ff) begin
               if (!shup_prio_ff || (slot_rdata.prio > prio_ff)) begin
                  slot_we    = 1'b1;
                  slot_waddr = pix_ff + AW'(1);
                  pos_in     = CW'(pix_ff);
               end else begin
                  pend_in  = 1'b0;
                  state_in = S_PUT;
               end
            end else if (exhaust) begin
               state_in = S_PUT;
            end
         end

         // Store the new job at the freed slot
         S_PUT: begin
            slot_we    = 1'b1;
            slot_waddr = AW'(pos_ff);
            slot_wdata = ent_ff;
            occ_in     = occ_ff + CW'(1);
            state_in   = S_DONE;
         end

         // Close the gap left by a removed job
         S_SHDN: begin
            if (pend_ff) begin
               slot_we    = 1'b1;
               slot_waddr = pix_ff - AW'(1);
            end else if (exhaust) begin
               occ_in   = occ_ff - CW'(1);
               state_in = S_DONE;
            end
         end

         // Sum pages of all jobs no longer than the target
         S_SUM: begin
            if (pend_ff && (slot_rdata.pages <= ent_ff.pages)) begin
               sum_in = sum_ff + SW'(slot_rdata.pages);
            end
            if (exhaust) begin
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            prod_in  = PW'(sum_ff) * PW'(spp_ff);
            state_in = S_DONE;
         end

         // Hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = {6'd0,
                              ((act_ff == ActQuery) && (status_ff == StOk)) ?
                                 wait_sat : 32'd0,
                              ent_ff.src, ent_ff.prio, ent_ff.pages, ent_ff.ident,
                              status_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         nid_ff        <= '0;
         order_mode_ff <= ModePrio;
         spp_ff        <= SecPerPageReset;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         nid_ff       <= nid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CsrOrderMode:  order_mode_ff <= csr_wdata[1:0];
               CsrSecPerPage: spp_ff        <= csr_wdata;
               default:       spp_ff        <= spp_ff;
            endcase
         end
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      pages_ff     <= pages_in;
      prio_ff      <= prio_in;
      src_ff       <= src_in;
      target_ff    <= target_in;
      ix_ff        <= ix_in;
      lo_ff        <= lo_in;
      pos_ff       <= pos_in;
      pix_ff       <= pix_in;
      shup_prio_ff <= shup_prio_in;
      ent_ff       <= ent_in;
      status_ff    <= status_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      slot_we |-> (state_ff == S_SHUP || state_ff == S_SHDN || state_ff == S_PUT))
      else $error("slot write outside a shift or insert");

   a_occ_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_PUT && state_ff != S_SHDN) |=> $stable(occ_ff))
      else $error("occupancy changed outside insert or removal");

   a_ident_stable: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(nid_ff))
      else $error("job id counter moved without an accepted item");

endmodule

// ===== sv/jqsjn_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jqsjn_slot_ram: job slot storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jqsjn_slot_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  jqsjn_pkg::job_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output jqsjn_pkg::job_type  rd_data_ff
);
   import jqsjn_pkg::*;

   job_type mem [DEPTH];

   // Write and read the slot array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
